FILE: design/assert_macros.svh
// Assertion helpers for the allocator module.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Implication checked on every rising clock edge outside reset.
`define ASSERT_IMPL(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Implication whose consequent is checked in the following cycle.
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

FILE: design/ffpa_pkg.sv
// ----------------------------------------------------------------------------
// ffpa_pkg
// Types and constants for the first-fit page allocator.
// ----------------------------------------------------------------------------
`default_nettype none
package ffpa_pkg;
    localparam int unsigned PageBitsDef   = 20;
    localparam int unsigned MaxExtentsDef = 64;

    localparam logic [1:0] OP_ALLOC = 2'd0;
    localparam logic [1:0] OP_FREE  = 2'd1;
    localparam logic [1:0] OP_ADD   = 2'd2;
    localparam logic [1:0] OP_NOP   = 2'd3;

    localparam logic [1:0] ST_OK    = 2'd0;
    localparam logic [1:0] ST_NOFIT = 2'd1;
    localparam logic [1:0] ST_FULL  = 2'd2;
    localparam logic [1:0] ST_ZERO  = 2'd3;

    typedef struct packed {
        logic [1:0]  op;
        logic [19:0] page_index;
        logic [20:0] page_count;
    } t_in_item;

    typedef struct packed {
        logic [1:0]  status;
        logic [19:0] granted_page;
        logic [20:0] free_total;
    } t_out_item;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SCAN_REQ,
        S_SCAN_CHK,
        S_DECIDE,
        S_SHIFT_UP_RD,
        S_SHIFT_UP_WR,
        S_SHIFT_DN_RD,
        S_SHIFT_DN_WR,
        S_WRITE,
        S_DONE
    } t_state;
endpackage
`default_nettype wire

FILE: design/first_fit_page_allocator.sv
// ----------------------------------------------------------------------------
// first_fit_page_allocator
// Steps: each table entry scanned takes a read request state and a check
//   state, and each entry moved on insert or removal takes a read state and a
//   write state, since the table RAM has a single read port.
// Throughput: one operation at a time; the next input transfer is taken
//   once the previous result has been transferred out.
// Reset: extent count and free total clear to zero; the table RAM is not
//   cleared, since only entries below the count are ever read.
// ----------------------------------------------------------------------------
`default_nettype none
module first_fit_page_allocator
    import ffpa_pkg::*;
#(
    parameter int unsigned PAGE_BITS   = PageBitsDef,
    parameter int unsigned MAX_EXTENTS = MaxExtentsDef
) (
    input  wire logic      i_clk,
    input  wire logic      i_rst_n,
    input  wire logic      i_in_valid,
    output logic           o_in_stall,
    input  wire t_in_item  i_in_data,
    output logic           o_out_valid,
    input  wire logic      i_out_stall,
    output t_out_item      o_out_data
);
    `include "assert_macros.svh"

    localparam int unsigned AW = $clog2(MAX_EXTENTS);
    localparam int unsigned CW = AW + 1;
    localparam int unsigned NW = PAGE_BITS + 1;
    localparam int unsigned EW = PAGE_BITS + NW;
    localparam logic [CW-1:0] CntMax = CW'(MAX_EXTENTS);
    localparam logic [NW:0]  Span   = (NW+1)'(1) << PAGE_BITS;

    t_state r_state, n_state;
    logic [CW-1:0] r_cnt, n_cnt;
    logic [NW-1:0] r_total, n_total;
    logic [1:0]    r_op;
    logic [PAGE_BITS-1:0] r_base;
    logic [NW-1:0] r_n;
    logic [CW-1:0] r_idx, n_idx;
    logic [CW-1:0] r_pos, n_pos;
    logic [PAGE_BITS-1:0] r_ps, n_ps;   // previous entry seen in scan
    logic [NW-1:0] r_pl, n_pl;
    logic [PAGE_BITS-1:0] r_cs, n_cs;   // entry at pos
    logic [NW-1:0] r_cl, n_cl;
    logic r_mp, n_mp;                   // merge flags held from the decision
    logic r_mn, n_mn;
    logic r_out_v, n_out_v;
    t_out_item r_out, n_out;

    logic          ram_we;
    logic [AW-1:0] ram_wa, ram_ra;
    logic [EW-1:0] ram_wd, ram_rd;
    logic [PAGE_BITS-1:0] rd_s;
    logic [NW-1:0]        rd_l;

    ffpa_ram #(.Width(EW), .Depth(MAX_EXTENTS)) u_table (
        .i_clk  (i_clk),
        .i_we   (ram_we),
        .i_waddr(ram_wa),
        .i_wdata(ram_wd),
        .i_raddr(ram_ra),
        .o_rdata(ram_rd)
    );
    assign rd_s = ram_rd[EW-1:NW];
    assign rd_l = ram_rd[NW-1:0];

    // Merge checks of a freed range against its neighbouring entries.
    logic          mp, mn;
    logic [NW+1:0] end_prev;
    logic [NW:0]   end_new;
    assign end_prev = (NW+2)'(r_ps) + (NW+2)'(r_pl);
    assign end_new  = (NW+1)'(r_base) + (NW+1)'(r_n);
    assign mp = (r_op == OP_FREE) && (r_pos != '0) && (end_prev == (NW+2)'(r_base));
    assign mn = (r_op == OP_FREE) && (r_pos < r_cnt) && (end_new == (NW+1)'(r_cs));

    logic in_acc;
    assign in_acc     = i_in_valid && !o_in_stall;
    assign o_in_stall = (r_state != S_IDLE) || r_out_v;
    assign o_out_valid = r_out_v;
    assign o_out_data  = r_out;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_cnt   <= '0;
            r_total <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            r_cnt   <= n_cnt;
            r_total <= n_total;
            r_out_v <= n_out_v;
        end
        if (in_acc) begin
            r_op   <= i_in_data.op;
            r_base <= PAGE_BITS'(i_in_data.page_index);
            r_n    <= NW'(i_in_data.page_count);
        end
        r_idx <= n_idx;
        r_pos <= n_pos;
        r_ps  <= n_ps;
        r_pl  <= n_pl;
        r_cs  <= n_cs;
        r_cl  <= n_cl;
        r_mp  <= n_mp;
        r_mn  <= n_mn;
        r_out <= n_out;
    end

    // Next state.
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (in_acc) begin
                    if (i_in_data.op == OP_NOP || i_in_data.page_count == '0) begin
                        n_state = S_DONE;
                    end else begin
                        n_state = S_SCAN_REQ;
                    end
                end
            end
            S_SCAN_REQ: begin
                n_state = (r_idx < r_cnt) ? S_SCAN_CHK : S_DECIDE;
            end
            S_SCAN_CHK: begin
                if (r_op == OP_ALLOC) begin
                    n_state = (rd_l >= r_n) ? S_DECIDE : S_SCAN_REQ;
                end else begin
                    n_state = (rd_s > r_base) ? S_DECIDE : S_SCAN_REQ;
                end
            end
            S_DECIDE: begin
                if (r_op == OP_ALLOC) begin
                    if (r_n > r_total || r_pos >= r_cnt) n_state = S_DONE;
                    else if (r_cl > r_n) n_state = S_WRITE;
                    else n_state = S_SHIFT_DN_RD;
                end else if (end_new > Span || ((NW+1)'(r_total) + (NW+1)'(r_n)) > Span) begin
                    n_state = S_DONE;
                end else if (mp && mn) begin
                    n_state = S_WRITE;
                end else if (mp || mn) begin
                    n_state = S_WRITE;
                end else if (r_cnt >= CntMax) begin
                    n_state = S_DONE;
                end else if (r_cnt > r_pos) begin
                    n_state = S_SHIFT_UP_RD;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_SHIFT_UP_RD: n_state = S_SHIFT_UP_WR;
            S_SHIFT_UP_WR: n_state = (r_idx - 1'b1 > r_pos) ? S_SHIFT_UP_RD : S_WRITE;
            S_SHIFT_DN_RD: begin
                n_state = (r_idx + 1'b1 < r_cnt) ? S_SHIFT_DN_WR : S_DONE;
            end
            S_SHIFT_DN_WR: n_state = S_SHIFT_DN_RD;
            S_WRITE: begin
                n_state = (r_op == OP_FREE && r_mp && r_mn) ? S_SHIFT_DN_RD : S_DONE;
            end
            S_DONE: n_state = S_IDLE;
            default: n_state = S_IDLE;
        endcase
    end

    // Datapath and memory control.
    always_comb begin
        n_cnt   = r_cnt;
        n_total = r_total;
        n_idx   = r_idx;
        n_pos   = r_pos;
        n_ps    = r_ps;
        n_pl    = r_pl;
        n_cs    = r_cs;
        n_cl    = r_cl;
        n_mp    = r_mp;
        n_mn    = r_mn;
        n_out_v = r_out_v && i_out_stall;
        n_out   = r_out;
        ram_we  = 1'b0;
        ram_wa  = r_idx[AW-1:0];
        ram_wd  = {r_cs, r_cl};
        ram_ra  = r_idx[AW-1:0];
        case (r_state)
            S_IDLE: begin
                n_idx = '0;
                n_pos = '0;
                // The result register holds a waiting result until it is taken.
                if (in_acc) begin
                    n_out.status = ST_OK;
                    if (i_in_data.op != OP_NOP && i_in_data.page_count == '0) begin
                        n_out.status = ST_ZERO;
                    end
                    n_out.granted_page = '0;
                end
            end
            S_SCAN_REQ: begin
                n_pos = r_idx;
            end
            S_SCAN_CHK: begin
                n_cs = rd_s;
                n_cl = rd_l;
                if (!(r_op == OP_ALLOC ? rd_l >= r_n : rd_s > r_base)) begin
                    n_ps  = rd_s;
                    n_pl  = rd_l;
                    n_idx = r_idx + 1'b1;
                    n_pos = r_idx + 1'b1;
                end
            end
            S_DECIDE: begin
                n_out.status = ST_OK;
                n_idx = r_cnt;
                n_mp  = mp;
                n_mn  = mn;
                if (r_op == OP_ALLOC) begin
                    if (r_n > r_total || r_pos >= r_cnt) begin
                        n_out.status = ST_NOFIT;
                    end else begin
                        n_out.granted_page = 20'(r_cs);
                        n_total = r_total - r_n;
                        n_idx = r_pos;
                        if (r_cl > r_n) begin
                            n_cs = r_cs + PAGE_BITS'(r_n);
                            n_cl = r_cl - r_n;
                        end
                    end
                end else if (end_new > Span ||
                             ((NW+1)'(r_total) + (NW+1)'(r_n)) > Span) begin
                    n_out.status = ST_NOFIT;
                end else if (mp) begin
                    n_idx = r_pos - 1'b1;
                    n_cs  = r_ps;
                    n_cl  = mn ? r_pl + r_n + r_cl : r_pl + r_n;
                    n_total = r_total + r_n;
                end else if (mn) begin
                    n_idx = r_pos;
                    n_cs  = r_base;
                    n_cl  = r_cl + r_n;
                    n_total = r_total + r_n;
                end else if (r_cnt >= CntMax) begin
                    n_out.status = ST_FULL;
                end else begin
                    n_cs = r_base;
                    n_cl = r_n;
                    n_total = r_total + r_n;
                    if (r_cnt <= r_pos) n_idx = r_pos;
                end
            end
            S_SHIFT_UP_RD: begin
                ram_ra = AW'(r_idx - 1'b1);
            end
            S_SHIFT_UP_WR: begin
                ram_we = 1'b1;
                ram_wd = ram_rd;
                n_idx  = r_idx - 1'b1;
            end
            S_SHIFT_DN_RD: begin
                ram_ra = AW'(r_idx + 1'b1);
                if (!(r_idx + 1'b1 < r_cnt)) n_cnt = r_cnt - 1'b1;
            end
            S_SHIFT_DN_WR: begin
                ram_we = 1'b1;
                ram_wd = ram_rd;
                n_idx  = r_idx + 1'b1;
            end
            S_WRITE: begin
                ram_we = 1'b1;
                if (r_op != OP_ALLOC && !r_mp && !r_mn) n_cnt = r_cnt + 1'b1;
                if (r_op == OP_FREE && r_mp && r_mn) n_idx = r_pos;
            end
            S_DONE: begin
                n_out_v = 1'b1;
                n_out.free_total = 21'(r_total);
            end
            default: ;
        endcase
    end

    `ASSERT_IMPL(a_cnt_range, i_clk, i_rst_n, 1'b1, r_cnt <= CntMax,
        "extent count above table size")
    `ASSERT_IMPL(a_total_range, i_clk, i_rst_n, 1'b1, r_total <= NW'(Span),
        "free total above page span")
    `ASSERT_NEXT(a_out_follows_done, i_clk, i_rst_n, r_state == S_DONE, r_out_v,
        "result not presented after completion")
endmodule
`default_nettype wire

FILE: design/ffpa_ram.sv
// ----------------------------------------------------------------------------
// ffpa_ram
// Generic single-port write, single-port read RAM with registered read.
// ----------------------------------------------------------------------------
`default_nettype none
module ffpa_ram #(
    parameter int unsigned Width = 8,
    parameter int unsigned Depth = 16
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(Depth)-1:0] i_waddr,
    input  wire logic [Width-1:0]         i_wdata,
    input  wire logic [$clog2(Depth)-1:0] i_raddr,
    output logic      [Width-1:0]         o_rdata
);
    logic [Width-1:0] r_mem [Depth];
    logic [Width-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata = r_rdata;
endmodule
`default_nettype wire

FILE: dv/first_fit_page_allocator_tb.sv
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// first_fit_page_allocator_tb
// Drives allocate, free, add-region and no-op transfers into the page allocator,
// predicts every result from a model of the sorted extent table, and checks
// each result field by field in order.
// ----------------------------------------------------------------------------
`default_nettype none

class extent_scoreboard;
    localparam longint unsigned Span = 64'd1 << 20;
    localparam int MaxExt = 64;

    longint unsigned ext_start[$];
    longint unsigned ext_len[$];
    longint unsigned avail_pages;
    ffpa_pkg::t_out_item pending[$];
    int errors;

    function new();
        avail_pages = 0;
        errors = 0;
    endfunction

    function logic [1:0] allocate(longint unsigned n, output longint unsigned granted);
        granted = 0;
        if (n > avail_pages) return ffpa_pkg::ST_NOFIT;
        foreach (ext_len[i]) begin
            if (ext_len[i] >= n) begin
                granted = ext_start[i];
                if (ext_len[i] > n) begin
                    ext_start[i] += n;
                    ext_len[i] -= n;
                end else begin
                    ext_start.delete(i);
                    ext_len.delete(i);
                end
                avail_pages -= n;
                return ffpa_pkg::ST_OK;
            end
        end
        return ffpa_pkg::ST_NOFIT;
    endfunction

    function logic [1:0] insert(longint unsigned base, longint unsigned n, bit merge);
        int pos;
        bit below;
        bit above;
        below = 0;
        above = 0;
        if (base + n > Span || avail_pages + n > Span) return ffpa_pkg::ST_NOFIT;
        pos = ext_start.size();
        foreach (ext_start[i]) begin
            if (ext_start[i] > base) begin
                pos = i;
                break;
            end
        end
        if (merge) begin
            below = pos > 0 && ext_start[pos-1] + ext_len[pos-1] == base;
            above = pos < ext_start.size() && base + n == ext_start[pos];
        end
        if (below && above) begin
            ext_len[pos-1] += n + ext_len[pos];
            ext_start.delete(pos);
            ext_len.delete(pos);
        end else if (below) begin
            ext_len[pos-1] += n;
        end else if (above) begin
            ext_start[pos] = base;
            ext_len[pos] += n;
        end else begin
            if (ext_start.size() >= MaxExt) return ffpa_pkg::ST_FULL;
            ext_start.insert(pos, base);
            ext_len.insert(pos, n);
        end
        avail_pages += n;
        return ffpa_pkg::ST_OK;
    endfunction

    function void note_request(ffpa_pkg::t_in_item req);
        ffpa_pkg::t_out_item res;
        longint unsigned granted;
        granted = 0;
        res.status = ffpa_pkg::ST_OK;
        if (req.op == ffpa_pkg::OP_NOP) begin
            res.status = ffpa_pkg::ST_OK;
        end else if (req.page_count == 0) begin
            res.status = ffpa_pkg::ST_ZERO;
        end else if (req.op == ffpa_pkg::OP_ALLOC) begin
            res.status = allocate(req.page_count, granted);
        end else begin
            res.status = insert(req.page_index, req.page_count,
                                req.op == ffpa_pkg::OP_FREE);
        end
        res.granted_page = granted[19:0];
        res.free_total = avail_pages[20:0];
        pending.push_back(res);
    endfunction

    function void check_result(ffpa_pkg::t_out_item got);
        ffpa_pkg::t_out_item exp;
        if (pending.size() == 0) begin
            $display("%0t: unexpected result %h", $time, got);
            errors++;
            return;
        end
        exp = pending.pop_front();
        if (got.status !== exp.status) begin
            $display("%0t: status expected %0d actual %0d", $time, exp.status, got.status);
            errors++;
        end
        if (got.granted_page !== exp.granted_page) begin
            $display("%0t: granted_page expected %h actual %h", $time,
                     exp.granted_page, got.granted_page);
            errors++;
        end
        if (got.free_total !== exp.free_total) begin
            $display("%0t: free_total expected %h actual %h", $time,
                     exp.free_total, got.free_total);
            errors++;
        end
    endfunction
endclass

module first_fit_page_allocator_tb;
    import ffpa_pkg::*;

    localparam int CycleLimit = 1500000;

    logic      i_clk = 1'b0;
    logic      i_rst_n = 1'b0;
    logic      in_valid = 1'b0;
    logic      in_stall;
    t_in_item  in_data = '0;
    logic      out_valid;
    logic      out_stall = 1'b0;
    t_out_item out_data;

    bit  quiet_sender = 0;
    bit  quiet_receiver = 0;
    bit  long_hold = 0;
    int  cycles = 0;
    extent_scoreboard board = new();

    first_fit_page_allocator DUT (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (in_valid),
        .o_in_stall (in_stall),
        .i_in_data  (in_data),
        .o_out_valid(out_valid),
        .i_out_stall(out_stall),
        .o_out_data (out_data)
    );

    always begin
        #5 i_clk = 1'b1;
        #5 i_clk = 1'b0;
    end

    always @(posedge i_clk) begin
        cycles <= cycles + 1;
        if (cycles >= CycleLimit) begin
            $display("tb: failure");
            $finish;
        end
    end

    // Receiver: random stall, a long hold-off on request, results checked at the edge.
    always @(posedge i_clk) begin
        if (i_rst_n && out_valid && !out_stall) board.check_result(out_data);
        if (long_hold) out_stall <= 1'b1;
        else if (quiet_receiver) out_stall <= 1'b0;
        else out_stall <= ($urandom_range(99) < 9);
    end

    // Offers one request; the transfer is noted when it is accepted. Valid
    // drops only in an idle cycle, so back-to-back requests need one update.
    task automatic send(input logic [1:0] op, input logic [19:0] idx, input logic [20:0] cnt);
        t_in_item req;
        req.op = op;
        req.page_index = idx;
        req.page_count = cnt;
        while (!quiet_sender && $urandom_range(99) < 9) begin
            in_valid <= 1'b0;
            @(posedge i_clk);
        end
        in_valid <= 1'b1;
        in_data <= req;
        @(posedge i_clk);
        while (in_stall) @(posedge i_clk);
        board.note_request(req);
    endtask

    task automatic drain();
        in_valid <= 1'b0;
        while (board.pending.size() != 0) @(posedge i_clk);
    endtask

    // Mostly well-formed: frees give back previously granted extents.
    logic [19:0] held_start[$];
    logic [20:0] held_len[$];

    task automatic random_op(input int max_len);
        int pick;
        int k;
        logic [20:0] n;
        logic [19:0] b;
        pick = $urandom_range(99);
        n = 21'($urandom_range(max_len, 1));
        if (pick < 40) begin
            send(OP_ALLOC, 20'($urandom), n);
            if (board.pending[$].status == ST_OK) begin
                held_start.push_back(board.pending[$].granted_page);
                held_len.push_back(n);
            end
        end else if (pick < 75 && held_start.size() != 0) begin
            k = $urandom_range(held_start.size() - 1);
            send(OP_FREE, held_start[k], held_len[k]);
            held_start.delete(k);
            held_len.delete(k);
        end else if (pick < 85) begin
            b = 20'($urandom);
            send(OP_ADD, b, n);
        end else if (pick < 92) begin
            b = 20'($urandom);
            send(OP_FREE, b, n);
        end else if (pick < 95) begin
            send(2'($urandom_range(3)), 20'($urandom), 21'd0);
        end else if (pick < 97) begin
            send(OP_NOP, 20'($urandom), 21'($urandom));
        end else begin
            send(2'($urandom_range(2)), 20'($urandom),
                 21'($urandom_range(21'h100000, 21'h0F0000)));
        end
    endtask

    initial begin
        int i;
        repeat (11) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        // Directed: zero counts, unused op, empty table, extremes.
        send(OP_ALLOC, 20'h0, 21'h0);
        send(OP_FREE, 20'hFFFFF, 21'h0);
        send(OP_NOP, 20'hFFFFF, 21'h1FFFFF);
        send(OP_ALLOC, 20'h0, 21'd1);
        send(OP_ADD, 20'hFFFFF, 21'd2);
        send(OP_ADD, 20'hFFFFF, 21'd1);
        send(OP_ADD, 20'h0, 21'h0FFFFF);
        send(OP_ADD, 20'h0, 21'd1);
        send(OP_ALLOC, 20'h0, 21'h100000);
        send(OP_ALLOC, 20'h0, 21'h0FFFFF);
        send(OP_ALLOC, 20'hFFFFF, 21'd1);
        send(OP_ALLOC, 20'h0, 21'd1);
        send(OP_FREE, 20'h0, 21'h100000);
        send(OP_ALLOC, 20'h0, 21'h100000);
        // Merging below, above, both; equal starts.
        send(OP_FREE, 20'd100, 21'd10);
        send(OP_FREE, 20'd120, 21'd10);
        send(OP_FREE, 20'd110, 21'd10);
        send(OP_FREE, 20'd90, 21'd10);
        send(OP_FREE, 20'd130, 21'd5);
        send(OP_ADD, 20'd90, 21'd3);
        send(OP_ADD, 20'd90, 21'd4);
        send(OP_ALLOC, 20'h0, 21'd200);
        send(OP_ALLOC, 20'h0, 21'd3);
        send(OP_ALLOC, 20'h0, 21'd45);
        drain();

        // Full table: many separate adds, then a non-merging free and a merging one.
        for (i = 0; i < 66; i++) send(OP_ADD, 20'(32'h10000 + i * 4), 21'd1);
        send(OP_FREE, 20'h80000, 21'd1);
        send(OP_FREE, 20'h10001, 21'd1);
        // Receiver holds off while the sender keeps offering.
        fork
            begin
                long_hold = 1;
                repeat (400) @(posedge i_clk);
                long_hold = 0;
            end
            for (i = 0; i < 20; i++) random_op(8);
        join
        // Sender waits for every result before going on.
        drain();
        for (i = 0; i < 70; i++) send(OP_ALLOC, 20'h0, 21'd1);
        drain();

        for (i = 0; i < 1200; i++) begin
            quiet_sender = (i >= 300 && i < 450);
            quiet_receiver = quiet_sender;
            random_op((i % 100 == 0) ? 32'h100000 : 64);
        end
        quiet_sender = 0;
        quiet_receiver = 0;
        drain();
        repeat (300) @(posedge i_clk);

        if (board.errors == 0 && board.pending.size() == 0) begin
            $display("tb: success");
        end else begin
            $display("tb: failure");
        end
        $finish;
    end
endmodule
`default_nettype wire
